### hw/rtl/afl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_pkg
// Shared constants, codes and controller/datapath bundles of the free list
// allocator.
// ----------------------------------------------------------------------------
package afl_pkg;

	localparam int ENTRIES   = 4096;
	localparam int DATA_W    = 64;
	localparam int SLOT_W    = 12;
	localparam int PAYLOAD_W = 64;
	localparam int ADDR_W    = $clog2(ENTRIES);
	localparam int LINK_W    = $clog2(ENTRIES + 1);

	// nil link is coded as the pool size
	localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(ENTRIES);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_DEALLOC = 2'd1,
		OP_READ    = 2'd2,
		OP_WRITE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RSP_DONE  = 2'd0,
		RSP_FULL  = 2'd1,
		RSP_EMPTY = 2'd2
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_DEAL_RD,
		S_DEAL_LINK,
		S_DEAL_SELF,
		S_DEAL_HEAD,
		S_READ_RD,
		S_READ_RSP,
		S_WRITE,
		S_REJECT
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic alloc_rd;
		logic alloc_wr;
		logic deal_rd;
		logic deal_link;
		logic deal_self;
		logic deal_head;
		logic read_rd;
		logic read_rsp;
		logic write_do;
		logic reject;
	} cmd_t;

	typedef struct packed {
		logic used_nil;
		logic free_nil;
		logic slot_ok;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

### hw/rtl/afl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_req_if
// Request channel of the allocator: operation, slot and payload.
// ----------------------------------------------------------------------------
interface afl_req_if;
	logic                            valid;
	logic                            ready;
	afl_pkg::op_t                    op;
	logic [afl_pkg::SLOT_W-1:0]      slot;
	logic [afl_pkg::PAYLOAD_W-1:0]   payload;

	modport source (output valid, output op, output slot, output payload, input ready);
	modport sink (input valid, input op, input slot, input payload, output ready);
endinterface

### hw/rtl/afl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_rsp_if
// Response channel of the allocator: status, granted slot and read data.
// ----------------------------------------------------------------------------
interface afl_rsp_if;
	logic                            valid;
	logic                            ready;
	afl_pkg::rsp_t                   status;
	logic [afl_pkg::SLOT_W-1:0]      granted_slot;
	logic [afl_pkg::PAYLOAD_W-1:0]   read_data;

	modport source (output valid, output status, output granted_slot, output read_data,
		input ready);
	modport sink (input valid, input status, input granted_slot, input read_data,
		output ready);
endinterface

### hw/rtl/afl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_ram
// Simple dual port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module afl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/afl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_ctrl
// Sequencer of the allocator: clearing pass, request decode and the memory
// access steps of each operation.
// ----------------------------------------------------------------------------
module afl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  afl_pkg::op_t   req_op,
	input  afl_pkg::stat_t stat,
	output afl_pkg::cmd_t  cmd,
	output logic           req_ready
);
	import afl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   fire;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	// final steps wait until the output register can take the response
	assign fire      = stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (req_op)
						OP_ALLOC:   state_d = stat.free_nil ? S_REJECT : S_ALLOC_RD;
						OP_DEALLOC: state_d = (!stat.used_nil && stat.slot_ok) ?
							S_DEAL_RD : S_REJECT;
						OP_READ:    state_d = stat.slot_ok ? S_READ_RD : S_REJECT;
						OP_WRITE:   state_d = S_WRITE;
						default:    state_d = S_REJECT;
					endcase
				end
			end
			S_ALLOC_RD:  state_d = S_ALLOC_WR;
			S_DEAL_RD:   state_d = S_DEAL_LINK;
			S_DEAL_LINK: state_d = S_DEAL_SELF;
			S_DEAL_SELF: state_d = S_DEAL_HEAD;
			S_READ_RD:   state_d = S_READ_RSP;
			S_ALLOC_WR, S_DEAL_HEAD, S_READ_RSP, S_WRITE, S_REJECT: begin
				if (fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		unique case (state_q)
			S_CLEAR:     cmd.clear     = 1'b1;
			S_ALLOC_RD:  cmd.alloc_rd  = 1'b1;
			S_ALLOC_WR:  cmd.alloc_wr  = fire;
			S_DEAL_RD:   cmd.deal_rd   = 1'b1;
			S_DEAL_LINK: cmd.deal_link = 1'b1;
			S_DEAL_SELF: cmd.deal_self = 1'b1;
			S_DEAL_HEAD: cmd.deal_head = fire;
			S_READ_RD:   cmd.read_rd   = 1'b1;
			S_READ_RSP:  cmd.read_rsp  = fire;
			S_WRITE:     cmd.write_do  = fire;
			S_REJECT:    cmd.reject    = fire;
			default: ;
		endcase
	end

endmodule

### hw/rtl/afl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_datapath
// Link and value memories, list heads, request capture and response register.
// ----------------------------------------------------------------------------
module afl_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  afl_pkg::cmd_t                  cmd,
	output afl_pkg::stat_t                 stat,
	input  afl_pkg::op_t                   req_op,
	input  logic [afl_pkg::SLOT_W-1:0]     req_slot,
	input  logic [afl_pkg::PAYLOAD_W-1:0]  req_payload,
	afl_rsp_if.source                      rsp
);
	import afl_pkg::*;

	logic [LINK_W-1:0] used_head_q;
	logic [LINK_W-1:0] free_head_q;
	logic [ADDR_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0] data_q;
	rsp_t              code_q;

	logic              out_valid_q;
	rsp_t              out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [PAYLOAD_W-1:0] out_data_q;

	logic              nx_we, nx_re, pv_we, pv_re, vl_we, vl_re;
	logic [ADDR_W-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr, vl_waddr, vl_raddr;
	logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rd, pv_rd;
	logic [DATA_W-1:0] vl_rd;

	logic [ADDR_W-1:0] cur_a;
	logic [ADDR_W-1:0] slot_a;
	logic [LINK_W-1:0] slot_l;
	logic              slot_q_ok;
	logic              out_load;

	assign cur_a     = free_head_q[ADDR_W-1:0];
	assign slot_a    = ADDR_W'(slot_q);
	assign slot_l    = LINK_W'(slot_q);
	assign slot_q_ok = 32'(slot_q) < 32'(ENTRIES);

	assign stat.used_nil = (used_head_q >= LINK_NIL);
	assign stat.free_nil = (free_head_q >= LINK_NIL);
	assign stat.slot_ok  = 32'(req_slot) < 32'(ENTRIES);
	assign stat.clr_last = (clr_q == ADDR_W'(ENTRIES - 1));
	assign stat.out_free = !out_valid_q || rsp.ready;

	afl_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(nx_re), .raddr(nx_raddr), .rdata(nx_rd)
	);

	afl_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.re(pv_re), .raddr(pv_raddr), .rdata(pv_rd)
	);

	afl_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_value (
		.clk(clk), .we(vl_we), .waddr(vl_waddr), .wdata(data_q),
		.re(vl_re), .raddr(vl_raddr), .rdata(vl_rd)
	);

	// memory port steering, one access per port per step
	always_comb begin
		nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_re = 1'b0; nx_raddr = '0;
		pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_re = 1'b0; pv_raddr = '0;
		vl_we = 1'b0; vl_waddr = '0; vl_re = 1'b0; vl_raddr = '0;
		if (cmd.clear) begin
			nx_we    = 1'b1;
			nx_waddr = clr_q;
			nx_wdata = LINK_W'(clr_q) + LINK_W'(1);
			pv_we    = 1'b1;
			pv_waddr = clr_q;
			pv_wdata = (clr_q == '0) ? LINK_NIL : LINK_W'(clr_q) - LINK_W'(1);
		end
		if (cmd.alloc_rd) begin
			nx_re    = 1'b1;
			nx_raddr = cur_a;
			nx_we    = !stat.used_nil;
			nx_waddr = used_head_q[ADDR_W-1:0];
			nx_wdata = free_head_q;
			pv_we    = 1'b1;
			pv_waddr = cur_a;
			pv_wdata = used_head_q;
			vl_we    = 1'b1;
			vl_waddr = cur_a;
		end
		if (cmd.alloc_wr) begin
			// nx_rd holds the entry after the popped one
			nx_we    = 1'b1;
			nx_waddr = cur_a;
			nx_wdata = LINK_NIL;
			pv_we    = (nx_rd != LINK_NIL);
			pv_waddr = nx_rd[ADDR_W-1:0];
			pv_wdata = LINK_NIL;
		end
		if (cmd.deal_rd) begin
			nx_re    = 1'b1;
			nx_raddr = slot_a;
			pv_re    = 1'b1;
			pv_raddr = slot_a;
		end
		if (cmd.deal_link) begin
			nx_we    = (pv_rd != LINK_NIL);
			nx_waddr = pv_rd[ADDR_W-1:0];
			nx_wdata = nx_rd;
			pv_we    = (nx_rd != LINK_NIL);
			pv_waddr = nx_rd[ADDR_W-1:0];
			pv_wdata = pv_rd;
		end
		if (cmd.deal_self) begin
			nx_we    = 1'b1;
			nx_waddr = slot_a;
			nx_wdata = free_head_q;
			pv_we    = 1'b1;
			pv_waddr = slot_a;
			pv_wdata = LINK_NIL;
		end
		if (cmd.deal_head) begin
			pv_we    = !stat.free_nil;
			pv_waddr = cur_a;
			pv_wdata = slot_l;
		end
		if (cmd.read_rd) begin
			vl_re    = 1'b1;
			vl_raddr = slot_a;
		end
		if (cmd.write_do) begin
			vl_we    = slot_q_ok;
			vl_waddr = slot_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_head_q <= LINK_NIL;
			free_head_q <= '0;
			clr_q       <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.alloc_wr) begin
				used_head_q <= free_head_q;
				free_head_q <= nx_rd;
			end
			if (cmd.deal_head) begin
				if (used_head_q == slot_l) used_head_q <= pv_rd;
				free_head_q <= slot_l;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= req_slot;
			data_q <= req_payload[DATA_W-1:0];
			if (req_op == OP_ALLOC) begin
				code_q <= RSP_FULL;
			end else if (req_op == OP_DEALLOC && stat.used_nil) begin
				code_q <= RSP_EMPTY;
			end else begin
				code_q <= RSP_DONE;
			end
		end
	end

	assign out_load = cmd.alloc_wr || cmd.deal_head || cmd.read_rsp || cmd.write_do ||
		cmd.reject;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= cmd.reject ? code_q : RSP_DONE;
			out_slot_q   <= cmd.alloc_wr ? SLOT_W'(free_head_q) : '0;
			out_data_q   <= cmd.read_rsp ? PAYLOAD_W'(vl_rd) : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.granted_slot = out_slot_q;
	assign rsp.read_data    = out_data_q;

endmodule

### hw/rtl/array_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_free_list_allocator_core
// Free list allocator over a pool held as doubly linked lists in link RAMs.
// ----------------------------------------------------------------------------
// latency from request to response runs through the afl_ctrl states of each
// operation; one request at a time, next one taken while the response waits in
// the output register. the link RAM ports set the step count. after reset a
// clearing pass over all 4096 entries initialises the link RAMs, requests are
// held off until it ends; value RAM is not cleared.
module array_free_list_allocator_core (
	input  logic      clk,
	input  logic      arst_n,
	afl_req_if.sink   req,
	afl_rsp_if.source rsp
);
	import afl_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic ready;

	afl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_op(req.op),
		.stat(stat),
		.cmd(cmd),
		.req_ready(ready)
	);

	afl_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.req_op(req.op),
		.req_slot(req.slot),
		.req_payload(req.payload),
		.rsp(rsp)
	);

	assign req.ready = ready;

endmodule
